// ----- rtl/rcp_pkg.sv -----
package rcp_pkg;

  // Default widths of the argument count and bulk length limits
  localparam int ARG_COUNT_BITS_DEF = 16;
  localparam int BULK_LEN_BITS_DEF  = 32;

  // Reset values of the limit registers
  localparam logic [15:0] MAX_ARGS_RST     = 16'd1024;
  localparam logic [31:0] MAX_BULK_LEN_RST = 32'd536870912;

  // Configuration register indexes
  localparam logic CFG_MAX_ARGS     = 1'b0;
  localparam logic CFG_MAX_BULK_LEN = 1'b1;

  // Parser phases
  localparam logic [2:0] PH_STAR   = 3'd0;
  localparam logic [2:0] PH_COUNT  = 3'd1;
  localparam logic [2:0] PH_DOLLAR = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_TERM1  = 3'd5;
  localparam logic [2:0] PH_TERM2  = 3'd6;

  // Error codes
  localparam logic [3:0] ERR_NO_STAR   = 4'd0;
  localparam logic [3:0] ERR_BAD_COUNT = 4'd1;
  localparam logic [3:0] ERR_COUNT_LE0 = 4'd2;
  localparam logic [3:0] ERR_TOO_MANY  = 4'd3;
  localparam logic [3:0] ERR_NO_DOLLAR = 4'd4;
  localparam logic [3:0] ERR_BAD_LEN   = 4'd5;
  localparam logic [3:0] ERR_NEG_LEN   = 4'd6;
  localparam logic [3:0] ERR_TOO_LONG  = 4'd7;
  localparam logic [3:0] ERR_BAD_TERM  = 4'd8;

  // Characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Signed 64-bit magnitude limits
  localparam logic [67:0] LIM_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] LIM_NEG = 68'h0_8000_0000_0000_0000;

  // State of the count or length line being scanned
  typedef struct packed {
    logic [63:0] accum;
    logic        neg_seen;
    logic        digit_seen;
    logic        bad_text;
    logic        overflowed;
    logic        cr_pending;
  } line_t;

endpackage

// ----- rtl/resp_command_parser.sv -----
// RESP command parser: splits a byte stream of "*N CRLF ($L CRLF data CRLF) x N"
// commands into argument payload beats with their argument index.
// Input channel in_*: one raw stream byte per beat in in_tdata.
// Output channel out_*: exactly one result beat for each input beat, in order:
// a payload byte, an argument end, a command end, an error, or an all-zero
// idle result. Count and length errors and the end flags come on the closing LF
// of a line or terminator, other errors on the failing byte. After an error or a
// finished command the parser waits for '*'. cfg_*: limit registers, written
// only while the stream is idle, a user rule the block does not enforce. One
// beat is taken every cycle while out_tready is high. The per-byte step (a 68-bit
// multiply-by-ten add and compare for the digit accumulator, plus the phase
// decode) sits between the input register and the result register. Reset
// returns the parser to waiting for '*', empties both registers and loads the
// default limits. When out_tready is low the result register holds; the input
// register still takes one more beat, then in_tready drops.
module resp_command_parser #(
  parameter int ARG_COUNT_BITS = rcp_pkg::ARG_COUNT_BITS_DEF,
  parameter int BULK_LEN_BITS  = rcp_pkg::BULK_LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_byte, arg_index, error_code, zero fill
  output logic [3:0]  out_tuser,  // data_valid, arg_done, cmd_done, error_flag
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import rcp_pkg::*;

  localparam int AC_W = (ARG_COUNT_BITS < 16) ? ARG_COUNT_BITS : 16;
  localparam int BL_W = (BULK_LEN_BITS < 32) ? BULK_LEN_BITS : 32;

  localparam logic [15:0] ARG_LIM =
    (ARG_COUNT_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << ARG_COUNT_BITS) - 64'd1);
  localparam logic [31:0] BULK_LIM =
    (BULK_LEN_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << BULK_LEN_BITS) - 64'd1);
  localparam logic [15:0] ARG_CAP_RST =
    (MAX_ARGS_RST < ARG_LIM) ? MAX_ARGS_RST : ARG_LIM;
  localparam logic [31:0] BULK_CAP_RST =
    (MAX_BULK_LEN_RST < BULK_LIM) ? MAX_BULK_LEN_RST : BULK_LIM;

  // Limits, stored already capped to the counter widths
  logic [AC_W-1:0] arg_cap_r;
  logic [BL_W-1:0] bulk_cap_r;
  logic [15:0]     arg_cap_in;
  logic [31:0]     bulk_cap_in;

  // Pipeline control
  logic       s0_v_r, s0_v_nxt;
  logic [7:0] s0_byte_r;
  logic       out_v_r, out_v_nxt;
  logic       advance;

  // Parser state
  logic [2:0]      phase_r, phase_nxt;
  line_t           line_r, line_nxt;
  logic [AC_W-1:0] args_total_r, args_total_nxt;
  logic [AC_W-1:0] arg_pos_r, arg_pos_nxt;
  logic [BL_W-1:0] bytes_left_r, bytes_left_nxt;

  // Result fields
  logic        dv, ad, cd, ef;
  logic [7:0]  db;
  logic [15:0] ai;
  logic [3:0]  ec;
  logic [31:0] out_tdata_r;
  logic [3:0]  out_tuser_r;

  // Line scanner signals
  line_t       lscan;
  logic        line_end;
  logic        line_ok;
  logic        first_chr;
  logic        is_digit;
  logic [67:0] prod;
  logic [67:0] lim;
  logic        bad_cr;

  // Widened views
  logic [AC_W+15:0] arg_pos_ext;
  logic [AC_W+63:0] arg_cap_ext;
  logic [BL_W+63:0] bulk_cap_ext;
  logic [AC_W-1:0]  arg_pos_inc;

  assign advance   = s0_v_r && (!out_v_r || out_tready);
  assign in_tready = !s0_v_r || advance;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign arg_pos_ext  = {16'b0, arg_pos_r};
  assign arg_cap_ext  = {64'b0, arg_cap_r};
  assign bulk_cap_ext = {64'b0, bulk_cap_r};
  assign arg_pos_inc  = arg_pos_r + 1'b1;

  // Cap incoming limit writes
  assign arg_cap_in  = (cfg_wdata[15:0] < ARG_LIM) ? cfg_wdata[15:0] : ARG_LIM;
  assign bulk_cap_in = (cfg_wdata < BULK_LIM) ? cfg_wdata : BULK_LIM;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_cap_r  <= ARG_CAP_RST[AC_W-1:0];
      bulk_cap_r <= BULK_CAP_RST[BL_W-1:0];
    end else if (cfg_we) begin
      if (cfg_addr == CFG_MAX_ARGS) begin
        arg_cap_r <= arg_cap_in[AC_W-1:0];
      end else begin
        bulk_cap_r <= bulk_cap_in[BL_W-1:0];
      end
    end
  end

  // Scan one byte of a count or length line
  always_comb begin
    lscan     = line_r;
    line_end  = 1'b0;
    bad_cr    = 1'b0;
    first_chr = 1'b0;
    is_digit  = (s0_byte_r >= CH_ZERO) && (s0_byte_r <= CH_NINE);
    lim       = line_r.neg_seen ? LIM_NEG : LIM_POS;
    prod      = ({4'b0, line_r.accum} << 3) + ({4'b0, line_r.accum} << 1)
              + {64'b0, s0_byte_r[3:0]};
    if (line_r.cr_pending && s0_byte_r == CH_LF) begin
      line_end         = 1'b1;
      lscan.cr_pending = 1'b0;
    end else begin
      // a lone CR counts as a bad character
      bad_cr           = line_r.cr_pending;
      lscan.cr_pending = 1'b0;
      lscan.bad_text   = line_r.bad_text | bad_cr;
      first_chr        = !(line_r.neg_seen || line_r.digit_seen || lscan.bad_text);
      if (s0_byte_r == CH_CR) begin
        lscan.cr_pending = 1'b1;
      end else if (s0_byte_r == CH_MINUS && first_chr) begin
        lscan.neg_seen = 1'b1;
      end else if (is_digit) begin
        lscan.digit_seen = 1'b1;
        if (!line_r.overflowed) begin
          if (prod > lim) begin
            lscan.overflowed = 1'b1;
          end else begin
            lscan.accum = prod[63:0];
          end
        end
      end else begin
        lscan.bad_text = 1'b1;
      end
    end
  end

  assign line_ok = line_r.digit_seen && !line_r.bad_text && !line_r.overflowed;

  // Phase decode and result
  always_comb begin
    phase_nxt      = phase_r;
    line_nxt       = line_r;
    args_total_nxt = args_total_r;
    arg_pos_nxt    = arg_pos_r;
    bytes_left_nxt = bytes_left_r;
    dv = 1'b0;
    db = 8'd0;
    ai = 16'd0;
    ad = 1'b0;
    cd = 1'b0;
    ef = 1'b0;
    ec = ERR_NO_STAR;
    unique case (phase_r)
      PH_STAR: begin
        if (s0_byte_r == CH_STAR) begin
          line_nxt  = '0;
          phase_nxt = PH_COUNT;
        end else begin
          ef = 1'b1;
          ec = ERR_NO_STAR;
        end
      end
      PH_COUNT: begin
        line_nxt = lscan;
        if (line_end) begin
          phase_nxt = PH_STAR;
          if (!line_ok) begin
            ef = 1'b1;
            ec = ERR_BAD_COUNT;
          end else if (line_r.neg_seen || line_r.accum == 64'd0) begin
            ef = 1'b1;
            ec = ERR_COUNT_LE0;
          end else if (line_r.accum > arg_cap_ext[63:0]) begin
            ef = 1'b1;
            ec = ERR_TOO_MANY;
          end else begin
            args_total_nxt = line_r.accum[AC_W-1:0];
            arg_pos_nxt    = '0;
            phase_nxt      = PH_DOLLAR;
          end
        end
      end
      PH_DOLLAR: begin
        if (s0_byte_r == CH_DOLLAR) begin
          line_nxt  = '0;
          phase_nxt = PH_LEN;
        end else begin
          ef        = 1'b1;
          ec        = ERR_NO_DOLLAR;
          phase_nxt = PH_STAR;
        end
      end
      PH_LEN: begin
        line_nxt = lscan;
        if (line_end) begin
          phase_nxt = PH_STAR;
          if (!line_ok) begin
            ef = 1'b1;
            ec = ERR_BAD_LEN;
          end else if (line_r.neg_seen && line_r.accum != 64'd0) begin
            ef = 1'b1;
            ec = ERR_NEG_LEN;
          end else if (line_r.accum > bulk_cap_ext[63:0]) begin
            ef = 1'b1;
            ec = ERR_TOO_LONG;
          end else begin
            bytes_left_nxt = line_r.accum[BL_W-1:0];
            phase_nxt      = (line_r.accum != 64'd0) ? PH_DATA : PH_TERM1;
          end
        end
      end
      PH_DATA: begin
        dv = 1'b1;
        db = s0_byte_r;
        ai = arg_pos_ext[15:0];
        bytes_left_nxt = bytes_left_r - 1'b1;
        if (bytes_left_r == {{(BL_W-1){1'b0}}, 1'b1}) begin
          phase_nxt = PH_TERM1;
        end
      end
      PH_TERM1: begin
        line_nxt.cr_pending = (s0_byte_r == CH_CR);
        phase_nxt           = PH_TERM2;
      end
      PH_TERM2: begin
        if (line_r.cr_pending && s0_byte_r == CH_LF) begin
          ad          = 1'b1;
          ai          = arg_pos_ext[15:0];
          arg_pos_nxt = arg_pos_inc;
          if (arg_pos_inc >= args_total_r) begin
            cd        = 1'b1;
            phase_nxt = PH_STAR;
          end else begin
            phase_nxt = PH_DOLLAR;
          end
        end else begin
          ef        = 1'b1;
          ec        = ERR_BAD_TERM;
          phase_nxt = PH_STAR;
        end
        line_nxt.cr_pending = 1'b0;
      end
      default: begin
        phase_nxt = PH_STAR;
      end
    endcase
  end

  // Handshake next values
  always_comb begin
    s0_v_nxt = s0_v_r;
    if (in_tvalid && in_tready) begin
      s0_v_nxt = 1'b1;
    end else if (advance) begin
      s0_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
    end
    if (in_tvalid && in_tready) begin
      s0_byte_r <= in_tdata;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      phase_r      <= PH_STAR;
      line_r       <= '0;
      args_total_r <= '0;
      arg_pos_r    <= '0;
      bytes_left_r <= '0;
    end else begin
      out_v_r <= out_v_nxt;
      if (advance) begin
        phase_r      <= phase_nxt;
        line_r       <= line_nxt;
        args_total_r <= args_total_nxt;
        arg_pos_r    <= arg_pos_nxt;
        bytes_left_r <= bytes_left_nxt;
      end
    end
    if (advance) begin
      out_tdata_r <= {4'b0, ec, ai, db};
      out_tuser_r <= {ef, cd, ad, dv};
    end
  end

endmodule
